// ===== hdl/pkr_pkg.sv =====
package pkr_pkg;

	localparam int POS_W  = 13;
	localparam int BIDX_W = 3;
	localparam int TS_W   = 64;
	localparam int VAL_W  = 32;
	localparam int BND_W  = 14;
	localparam int KEY_W  = 10;
	localparam int CIDX_W = 2;

	localparam logic signed [VAL_W-1:0] ESC_CHAR = 32'sh1b;

	localparam logic [CIDX_W-1:0] CFG_SCREEN_WIDTH   = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_SCREEN_HEIGHT  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_ESCAPE_KEYCODE = 2'd2;

	typedef enum logic [3:0] {
		OP_NONE        = 4'd0,
		OP_KEY_DOWN    = 4'd1,
		OP_KEY_UP      = 4'd2,
		OP_ALL_KEYS_UP = 4'd3,
		OP_ASCII       = 4'd4,
		OP_BTN_DOWN    = 4'd5,
		OP_BTN_UP      = 4'd6,
		OP_DX          = 4'd7,
		OP_DY          = 4'd8,
		OP_ABS_X       = 4'd9,
		OP_ABS_Y       = 4'd10,
		OP_CLEAR       = 4'd11
	} pkr_op_t;

	typedef enum logic [1:0] {
		KIND_MOTION = 2'd0,
		KIND_BUTTON = 2'd1,
		KIND_ESCAPE = 2'd2
	} pkr_kind_t;

	typedef struct packed {
		logic [3:0]              operation;
		logic signed [VAL_W-1:0] value;
		logic [TS_W-1:0]         timestamp_ms;
	} pkr_item_t;

	typedef struct packed {
		logic [1:0]        event_kind;
		logic [TS_W-1:0]   event_time_ms;
		logic [POS_W-1:0]  pointer_x_out;
		logic [POS_W-1:0]  pointer_y_out;
		logic [BIDX_W-1:0] button_index;
		logic              is_pressed;
		logic              is_repeat;
	} pkr_result_t;

	typedef struct packed {
		logic              wr;
		logic [CIDX_W-1:0] index;
		logic [BND_W-1:0]  data;
	} pkr_cfg_wr_t;

endpackage

// ===== hdl/pkr_event_if.sv =====
interface pkr_event_if;
	logic        valid;
	logic        ready;
	logic [3:0]  operation;
	logic signed [31:0] value;
	logic [63:0] timestamp_ms;

	modport source(output valid, operation, value, timestamp_ms, input ready);
	modport sink(input valid, operation, value, timestamp_ms, output ready);
endinterface

// ===== hdl/pkr_result_if.sv =====
interface pkr_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [63:0] event_time_ms;
	logic [12:0] pointer_x_out;
	logic [12:0] pointer_y_out;
	logic [2:0]  button_index;
	logic        is_pressed;
	logic        is_repeat;

	modport source(output valid, event_kind, event_time_ms, pointer_x_out, pointer_y_out,
		button_index, is_pressed, is_repeat, input ready);
	modport sink(input valid, event_kind, event_time_ms, pointer_x_out, pointer_y_out,
		button_index, is_pressed, is_repeat, output ready);
endinterface

// ===== hdl/pkr_cfg_if.sv =====
interface pkr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [13:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/pkr_in_stage.sv =====
module pkr_in_stage
	import pkr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  logic      advance,
	input  pkr_item_t item,
	output logic      valid_s1,
	output pkr_item_t item_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== hdl/pkr_core.sv =====
module pkr_core
	import pkr_pkg::*;
#(
	parameter int BUTTON_COUNT = 8,
	parameter int COORD_BITS   = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	input  pkr_cfg_wr_t cfg_wr,
	input  logic        advance,
	input  pkr_item_t   item_s1,
	output logic        res_en,
	output pkr_result_t res
);

	localparam int SUM_W   = 34;
	localparam int BI_W    = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
	localparam int LIM     = 1 << COORD_BITS;
	localparam int RST_W   = (640 > LIM) ? LIM : 640;
	localparam int RST_H   = (480 > LIM) ? LIM : 480;

	logic [COORD_BITS-1:0]   ptr_x_q, ptr_y_q;
	logic [COORD_BITS:0]     width_q, height_q;
	logic signed [KEY_W-1:0] esc_code_q;
	logic [BUTTON_COUNT-1:0] btn_mask_q;
	logic                    esc_held_q;

	logic [COORD_BITS-1:0]   ptr_x_d, ptr_y_d;
	logic [BUTTON_COUNT-1:0] btn_mask_d;
	logic                    esc_held_d;

	logic [BND_W-1:0]        bnd_raw;
	logic [COORD_BITS:0]     bnd_sat;
	logic [COORD_BITS-1:0]   ptr_x_cfg, ptr_y_cfg;

	logic signed [SUM_W-1:0] v_ext, sum_x, sum_y;
	logic [COORD_BITS-1:0]   new_x, new_y;
	logic                    btn_ok, key_match;
	logic [BI_W-1:0]         btn_sel;

	function automatic logic [COORD_BITS-1:0] clamp_to(logic signed [SUM_W-1:0] c,
		logic [COORD_BITS:0] extent);
		logic [COORD_BITS:0] top;
		top = extent - 1'b1;
		if (c[SUM_W-1]) begin
			return '0;
		end else if (c >= $signed({{(SUM_W-COORD_BITS-1){1'b0}}, extent})) begin
			return top[COORD_BITS-1:0];
		end else begin
			return c[COORD_BITS-1:0];
		end
	endfunction

	function automatic logic [POS_W-1:0] to_pos(logic [COORD_BITS-1:0] p);
		return POS_W'({{(32-COORD_BITS){1'b0}}, p});
	endfunction

	// bound write: saturate, then pull the pointer back inside the new range
	always_comb begin
		bnd_raw = cfg_wr.data;
		if ({18'b0, bnd_raw} > 32'(LIM)) begin
			bnd_sat = (COORD_BITS+1)'(LIM);
		end else begin
			bnd_sat = (COORD_BITS+1)'({18'b0, bnd_raw});
		end
		ptr_x_cfg = ptr_x_q;
		ptr_y_cfg = ptr_y_q;
		if ({1'b0, ptr_x_q} >= bnd_sat) begin
			ptr_x_cfg = COORD_BITS'(bnd_sat - 1'b1);
		end
		if ({1'b0, ptr_y_q} >= bnd_sat) begin
			ptr_y_cfg = COORD_BITS'(bnd_sat - 1'b1);
		end
	end

	always_comb begin
		v_ext     = {{(SUM_W-VAL_W){item_s1.value[VAL_W-1]}}, item_s1.value};
		sum_x     = $signed({{(SUM_W-COORD_BITS){1'b0}}, ptr_x_q}) + v_ext;
		sum_y     = $signed({{(SUM_W-COORD_BITS){1'b0}}, ptr_y_q}) - v_ext;
		new_x     = clamp_to(sum_x, width_q);
		new_y     = clamp_to(sum_y, height_q);
		btn_ok    = !item_s1.value[VAL_W-1] && (item_s1.value < VAL_W'(BUTTON_COUNT));
		btn_sel   = item_s1.value[BI_W-1:0];
		key_match = !esc_code_q[KEY_W-1] &&
			(item_s1.value == {{(VAL_W-KEY_W){1'b0}}, esc_code_q});
	end

	always_comb begin
		ptr_x_d    = ptr_x_q;
		ptr_y_d    = ptr_y_q;
		btn_mask_d = btn_mask_q;
		esc_held_d = esc_held_q;
		res_en     = 1'b0;
		res.event_kind    = KIND_MOTION;
		res.event_time_ms = item_s1.timestamp_ms;
		res.pointer_x_out = '0;
		res.pointer_y_out = '0;
		res.button_index  = '0;
		res.is_pressed    = 1'b0;
		res.is_repeat     = 1'b0;
		case (item_s1.operation)
			OP_DX: begin
				ptr_x_d = new_x;
				res_en  = (new_x != ptr_x_q);
				res.pointer_x_out = to_pos(new_x);
				res.pointer_y_out = to_pos(ptr_y_q);
			end
			OP_DY: begin
				ptr_y_d = new_y;
				res_en  = (new_y != ptr_y_q);
				res.pointer_x_out = to_pos(ptr_x_q);
				res.pointer_y_out = to_pos(new_y);
			end
			OP_BTN_DOWN, OP_BTN_UP: begin
				res.event_kind    = KIND_BUTTON;
				res.pointer_x_out = to_pos(ptr_x_q);
				res.pointer_y_out = to_pos(ptr_y_q);
				res.button_index  = item_s1.value[BIDX_W-1:0];
				res.is_pressed    = (item_s1.operation == OP_BTN_DOWN);
				if (btn_ok && (btn_mask_q[btn_sel] != res.is_pressed)) begin
					res_en = 1'b1;
					btn_mask_d[btn_sel] = res.is_pressed;
				end
			end
			OP_ASCII: begin
				res.event_kind = KIND_ESCAPE;
				res.is_pressed = 1'b1;
				res.is_repeat  = esc_held_q;
				if (item_s1.value == ESC_CHAR) begin
					res_en     = 1'b1;
					esc_held_d = 1'b1;
				end
			end
			OP_KEY_DOWN: begin
				res.event_kind = KIND_ESCAPE;
				res.is_pressed = 1'b1;
				res.is_repeat  = esc_held_q;
				if (key_match) begin
					res_en     = 1'b1;
					esc_held_d = 1'b1;
				end
			end
			OP_KEY_UP, OP_ALL_KEYS_UP: begin
				res.event_kind = KIND_ESCAPE;
				if (esc_held_q && (key_match || item_s1.operation == OP_ALL_KEYS_UP)) begin
					res_en     = 1'b1;
					esc_held_d = 1'b0;
				end
			end
			OP_CLEAR: begin
				btn_mask_d = '0;
				esc_held_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= (COORD_BITS+1)'(RST_W);
			height_q   <= (COORD_BITS+1)'(RST_H);
			esc_code_q <= '1;
			ptr_x_q    <= COORD_BITS'((RST_W - 1) / 2);
			ptr_y_q    <= COORD_BITS'((RST_H - 1) / 2);
			btn_mask_q <= '0;
			esc_held_q <= 1'b0;
		end else if (cfg_wr.wr) begin
			case (cfg_wr.index)
				CFG_SCREEN_WIDTH: begin
					if (bnd_raw != '0) begin
						width_q <= bnd_sat;
						ptr_x_q <= ptr_x_cfg;
					end
				end
				CFG_SCREEN_HEIGHT: begin
					if (bnd_raw != '0) begin
						height_q <= bnd_sat;
						ptr_y_q  <= ptr_y_cfg;
					end
				end
				CFG_ESCAPE_KEYCODE: begin
					esc_code_q <= cfg_wr.data[KEY_W-1:0];
					esc_held_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end else if (advance) begin
			ptr_x_q    <= ptr_x_d;
			ptr_y_q    <= ptr_y_d;
			btn_mask_q <= btn_mask_d;
			esc_held_q <= esc_held_d;
		end
	end

endmodule

// ===== hdl/pkr_out_stage.sv =====
module pkr_out_stage
	import pkr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  pkr_result_t res,
	input  logic        take,
	output logic        valid_q,
	output pkr_result_t res_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ===== hdl/pointer_key_event_reducer.sv =====
// Pointer and key event reducer.
// evt_in: raw events (operation, value, timestamp_ms), valid/ready; a beat is
//   taken when both are high. res_out: at most one result beat per event.
// cfg: register writes (0 screen width, 1 screen height, 2 escape keycode),
//   always ready; the user must write only while no event is in flight, as
//   the block itself does not enforce it.
// An event is registered on acceptance, evaluated against the pointer,
// button and escape state, and its result lands in the output register
// when the event advances; a stall at res_out holds the event back.
// Events are accepted at one per cycle while res_out does not stall; the
// single add-and-clamp per event sets the evaluation path.
// If res_out stalls with a result held, the event in the input register
// waits and evt_in accepts no further beat until the result is taken;
// events that yield no result still wait their turn so ordering holds.
// Reset restores 640x480 bounds, pointer at 319,239, buttons up, escape
// released and keycode matching off.
module pointer_key_event_reducer
	import pkr_pkg::*;
#(
	parameter int BUTTON_COUNT = 8,
	parameter int COORD_BITS   = 13
) (
	input logic   clk,
	input logic   arst_n,
	pkr_event_if.sink    evt_in,
	pkr_cfg_if.sink      cfg,
	pkr_result_if.source res_out
);

	pkr_item_t   item, item_s1;
	pkr_result_t res, res_q;
	pkr_cfg_wr_t cfg_wr;
	logic        valid_s1, advance, res_en, out_valid_q;

	assign item.operation    = evt_in.operation;
	assign item.value        = evt_in.value;
	assign item.timestamp_ms = evt_in.timestamp_ms;

	assign advance      = valid_s1 && (!out_valid_q || res_out.ready);
	assign evt_in.ready = !valid_s1 || advance;

	assign cfg.ready    = 1'b1;
	assign cfg_wr.wr    = cfg.valid;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data  = cfg.data;

	pkr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (evt_in.valid && evt_in.ready),
		.advance  (advance),
		.item     (item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	pkr_core #(
		.BUTTON_COUNT (BUTTON_COUNT),
		.COORD_BITS   (COORD_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_wr  (cfg_wr),
		.advance (advance),
		.item_s1 (item_s1),
		.res_en  (res_en),
		.res     (res)
	);

	pkr_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && res_en),
		.res     (res),
		.take    (res_out.ready),
		.valid_q (out_valid_q),
		.res_q   (res_q)
	);

	assign res_out.valid         = out_valid_q;
	assign res_out.event_kind    = res_q.event_kind;
	assign res_out.event_time_ms = res_q.event_time_ms;
	assign res_out.pointer_x_out = res_q.pointer_x_out;
	assign res_out.pointer_y_out = res_q.pointer_y_out;
	assign res_out.button_index  = res_q.button_index;
	assign res_out.is_pressed    = res_q.is_pressed;
	assign res_out.is_repeat     = res_q.is_repeat;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import pkr_pkg::*;

	localparam int WATCHDOG_CYCLES = 3000;
	localparam int HOLD_CYCLES     = 150;
	localparam int PHASES          = 8;
	localparam int PHASE_EVENTS    = 228;
	localparam int BUTTONS         = 8;
	localparam longint SCREEN_MAX  = longint'(1) << POS_W;

	localparam logic [3:0] OP_SPARE_LO = 4'd12;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;
	localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;

	logic clk;
	logic arst_n;

	pkr_event_if  evt();
	pkr_cfg_if    cfg_ch();
	pkr_result_if res();

	pointer_key_event_reducer dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt_in(evt),
		.cfg(cfg_ch),
		.res_out(res)
	);

	// shadow of the block's registers and state
	longint scr_w, scr_h, esc_code, ptr_x, ptr_y;
	logic [BUTTONS-1:0] btn_mask;
	bit esc_held;

	pkr_item_t   event_queue[$];
	pkr_result_t result_queue[$];

	int fails;
	bit evt_beat;
	int gap_left, stall_left, hold_left, hold_req, hold_seen;
	bit src_gaps, sink_gaps;
	pkr_item_t next_ev;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap(bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic longint clamp_axis(longint c, longint extent);
		if (c < 0)
			return 0;
		return (c >= extent) ? extent - 1 : c;
	endfunction

	function automatic void apply_register(logic [CIDX_W-1:0] idx, logic [BND_W-1:0] data);
		longint b;
		b = longint'(data);
		if (b > SCREEN_MAX)
			b = SCREEN_MAX;
		case (idx)
		CFG_SCREEN_WIDTH: begin
			// zero bound is dropped; pointer re-clamped into the new range
			if (b != 0) begin
				scr_w = b;
				ptr_x = clamp_axis(ptr_x, scr_w);
			end
		end
		CFG_SCREEN_HEIGHT: begin
			if (b != 0) begin
				scr_h = b;
				ptr_y = clamp_axis(ptr_y, scr_h);
			end
		end
		CFG_ESCAPE_KEYCODE: begin
			esc_code = longint'($signed(data[KEY_W-1:0]));
			esc_held = 1'b0;
		end
		default: ;
		endcase
	endfunction

	function automatic void reduce_event(pkr_item_t ev);
		longint v, moved;
		pkr_result_t r;
		bit hit, pressed;
		v = longint'($signed(ev.value));
		r = '0;
		r.event_time_ms = ev.timestamp_ms;
		hit = 1'b0;
		case (ev.operation)
		OP_DX: begin
			moved = clamp_axis(ptr_x + v, scr_w);
			if (moved != ptr_x) begin
				ptr_x = moved;
				hit = 1'b1;
				r.event_kind = KIND_MOTION;
			end
		end
		OP_DY: begin
			// y axis runs opposite to the delta
			moved = clamp_axis(ptr_y - v, scr_h);
			if (moved != ptr_y) begin
				ptr_y = moved;
				hit = 1'b1;
				r.event_kind = KIND_MOTION;
			end
		end
		OP_BTN_DOWN, OP_BTN_UP: begin
			pressed = (ev.operation == OP_BTN_DOWN);
			if (v >= 0 && v < BUTTONS && pressed != btn_mask[v]) begin
				btn_mask[v] = pressed;
				hit = 1'b1;
				r.event_kind = KIND_BUTTON;
				r.button_index = v[BIDX_W-1:0];
				r.is_pressed = pressed;
			end
		end
		OP_ASCII: begin
			if (v == ESC_CHAR) begin
				hit = 1'b1;
				r.event_kind = KIND_ESCAPE;
				r.is_pressed = 1'b1;
				r.is_repeat = esc_held;
				esc_held = 1'b1;
			end
		end
		OP_ALL_KEYS_UP: begin
			if (esc_held) begin
				hit = 1'b1;
				r.event_kind = KIND_ESCAPE;
				esc_held = 1'b0;
			end
		end
		OP_KEY_DOWN: begin
			if (esc_code >= 0 && v == esc_code) begin
				hit = 1'b1;
				r.event_kind = KIND_ESCAPE;
				r.is_pressed = 1'b1;
				r.is_repeat = esc_held;
				esc_held = 1'b1;
			end
		end
		OP_KEY_UP: begin
			if (esc_code >= 0 && v == esc_code && esc_held) begin
				hit = 1'b1;
				r.event_kind = KIND_ESCAPE;
				esc_held = 1'b0;
			end
		end
		OP_CLEAR: begin
			btn_mask = '0;
			esc_held = 1'b0;
		end
		default: ;
		endcase
		if (hit) begin
			if (r.event_kind != KIND_ESCAPE) begin
				r.pointer_x_out = ptr_x[POS_W-1:0];
				r.pointer_y_out = ptr_y[POS_W-1:0];
			end
			result_queue.push_back(r);
		end
	endfunction

	task automatic report(string msg);
		fails++;
		if (fails <= 50)
			$display("%0t ERROR %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [63:0] got_v, logic [63:0] want_v);
		if (got_v !== want_v)
			report($sformatf("%s: got %0h, expected %0h", name, got_v, want_v));
	endtask

	// monitor: predictor on event beats, checker on result beats, register shadow
	always @(posedge clk) begin
		pkr_item_t ev;
		pkr_result_t got, want;
		evt_beat = arst_n && evt.valid && evt.ready;
		if (evt_beat) begin
			ev.operation = evt.operation;
			ev.value = evt.value;
			ev.timestamp_ms = evt.timestamp_ms;
			reduce_event(ev);
		end
		if (arst_n && res.valid && res.ready) begin
			got.event_kind = res.event_kind;
			got.event_time_ms = res.event_time_ms;
			got.pointer_x_out = res.pointer_x_out;
			got.pointer_y_out = res.pointer_y_out;
			got.button_index = res.button_index;
			got.is_pressed = res.is_pressed;
			got.is_repeat = res.is_repeat;
			if (result_queue.size() == 0) begin
				report($sformatf("result beat with none pending: kind %0d time %0h",
					got.event_kind, got.event_time_ms));
			end else begin
				want = result_queue.pop_front();
				check_field("event_kind", got.event_kind, want.event_kind);
				check_field("event_time_ms", got.event_time_ms, want.event_time_ms);
				check_field("pointer_x_out", got.pointer_x_out, want.pointer_x_out);
				check_field("pointer_y_out", got.pointer_y_out, want.pointer_y_out);
				check_field("button_index", got.button_index, want.button_index);
				check_field("is_pressed", got.is_pressed, want.is_pressed);
				check_field("is_repeat", got.is_repeat, want.is_repeat);
			end
		end
		if (arst_n && cfg_ch.valid && cfg_ch.ready)
			apply_register(cfg_ch.index, cfg_ch.data);
	end

	// event driver
	always @(negedge clk) begin
		if (arst_n && (!evt.valid || evt_beat)) begin
			if (gap_left > 0) begin
				gap_left--;
				evt.valid <= 1'b0;
			end else if (event_queue.size() != 0) begin
				next_ev = event_queue.pop_front();
				evt.valid <= 1'b1;
				evt.operation <= next_ev.operation;
				evt.value <= next_ev.value;
				evt.timestamp_ms <= next_ev.timestamp_ms;
				gap_left = pick_gap(src_gaps);
			end else begin
				evt.valid <= 1'b0;
			end
		end
	end

	// result sink: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
			stall_left = pick_gap(sink_gaps);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((evt.valid && evt.ready) || (res.valid && res.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Regression FAIL");
		$finish;
	end

	task automatic queue_event(logic [3:0] op, logic signed [VAL_W-1:0] val,
		logic [TS_W-1:0] ts);
		pkr_item_t ev;
		ev.operation = op;
		ev.value = val;
		ev.timestamp_ms = ts;
		event_queue.push_back(ev);
	endtask

	// block is idle once nothing is queued, offered or owed, plus pipeline drain
	task automatic wait_quiet();
		do @(posedge clk);
		while (event_queue.size() != 0 || evt.valid || result_queue.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_register(logic [CIDX_W-1:0] idx, logic [BND_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = data;
		do @(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic logic signed [VAL_W-1:0] random_delta();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return int'($urandom_range(0, 40)) - 20;
		if (r < 88)
			return int'($urandom_range(0, 4000)) - 2000;
		return $urandom;
	endfunction

	function automatic pkr_item_t random_event();
		pkr_item_t ev;
		int r;
		r = $urandom_range(0, 99);
		ev.timestamp_ms = {$urandom, $urandom};
		if ($urandom_range(0, 19) == 0)
			ev.timestamp_ms = ($urandom_range(0, 1) != 0) ? '1 : '0;
		ev.value = $urandom;
		if (r < 22) begin
			ev.operation = OP_DX;
			ev.value = random_delta();
		end else if (r < 44) begin
			ev.operation = OP_DY;
			ev.value = random_delta();
		end else if (r < 58) begin
			ev.operation = ($urandom_range(0, 1) != 0) ? OP_BTN_DOWN : OP_BTN_UP;
			if ($urandom_range(0, 9) != 0)
				ev.value = $urandom_range(0, BUTTONS - 1);
			else if ($urandom_range(0, 1) != 0)
				ev.value = ($urandom_range(0, 1) != 0) ? -1 : BUTTONS;
		end else if (r < 66) begin
			ev.operation = OP_ASCII;
			if ($urandom_range(0, 9) < 6)
				ev.value = ESC_CHAR;
			else if ($urandom_range(0, 1) != 0)
				ev.value = $urandom_range(0, 127);
		end else if (r < 78) begin
			ev.operation = ($urandom_range(0, 1) != 0) ? OP_KEY_DOWN : OP_KEY_UP;
			if (esc_code >= 0 && $urandom_range(0, 99) < 65)
				ev.value = esc_code[VAL_W-1:0];
			else if ($urandom_range(0, 1) != 0)
				ev.value = $urandom_range(0, 511);
		end else if (r < 85) begin
			ev.operation = OP_ALL_KEYS_UP;
		end else if (r < 89) begin
			ev.operation = OP_CLEAR;
		end else if (r < 94) begin
			case ($urandom_range(0, 2))
			0: ev.operation = OP_NONE;
			1: ev.operation = OP_ABS_X;
			default: ev.operation = OP_ABS_Y;
			endcase
		end else begin
			ev.operation = 4'($urandom_range(0, 15));
		end
		return ev;
	endfunction

	initial begin : stimulus
		logic [BND_W-1:0] w, h, k;
		fails = 0;
		scr_w = 640;
		scr_h = 480;
		esc_code = -1;
		ptr_x = 319;
		ptr_y = 239;
		btn_mask = '0;
		esc_held = 1'b0;
		gap_left = 0;
		stall_left = 0;
		hold_left = 0;
		hold_req = 0;
		hold_seen = 0;
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		evt_beat = 1'b0;
		evt.valid = 1'b0;
		evt.operation = OP_NONE;
		evt.value = '0;
		evt.timestamp_ms = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_SCREEN_WIDTH;
		cfg_ch.data = '0;
		res.ready = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: pointer extremes, button edges, escape handling, ignored codes
		queue_event(OP_DX, 5, '0);
		queue_event(OP_DX, 32'sh7FFFFFFF, '1);
		queue_event(OP_DX, 0, 64'd3);
		queue_event(OP_DX, 32'sh80000000, 64'd4);
		queue_event(OP_DY, 10, 64'd5);
		queue_event(OP_DY, 32'sh80000000, 64'd6);
		queue_event(OP_DY, 32'sh7FFFFFFF, 64'd7);
		queue_event(OP_BTN_DOWN, 0, 64'd8);
		queue_event(OP_BTN_DOWN, 0, 64'd9);
		queue_event(OP_BTN_UP, 7, 64'd10);
		queue_event(OP_BTN_DOWN, 7, 64'd11);
		queue_event(OP_BTN_UP, 7, 64'd12);
		queue_event(OP_BTN_DOWN, BUTTONS, 64'd13);
		queue_event(OP_BTN_DOWN, -1, 64'd14);
		queue_event(OP_ASCII, ESC_CHAR, 64'd15);
		queue_event(OP_ASCII, ESC_CHAR, 64'd16);
		queue_event(OP_KEY_DOWN, 0, 64'd17);
		queue_event(OP_ALL_KEYS_UP, 0, 64'd18);
		queue_event(OP_ALL_KEYS_UP, 0, 64'd19);
		queue_event(OP_CLEAR, 0, 64'd20);
		queue_event(OP_BTN_DOWN, 0, 64'd21);
		queue_event(OP_NONE, -1, 64'd22);
		queue_event(OP_ABS_X, 100, 64'd23);
		queue_event(OP_SPARE_LO, 1, 64'd24);
		queue_event(OP_SPARE_HI, 0, 64'd24);
		wait_quiet();
		write_register(CFG_ESCAPE_KEYCODE, 14'd5);
		queue_event(OP_KEY_DOWN, 5, 64'd25);
		queue_event(OP_KEY_DOWN, 5, 64'd26);
		queue_event(OP_KEY_UP, 5, 64'd27);
		queue_event(OP_KEY_UP, 5, 64'd28);
		queue_event(OP_ASCII, ESC_CHAR, 64'd29);
		wait_quiet();
		// keycode write drops a held escape
		write_register(CFG_ESCAPE_KEYCODE, 14'd5);
		queue_event(OP_KEY_UP, 5, 64'd30);

		for (int p = 0; p < PHASES; p++) begin
			wait_quiet();
			case (p)
			0: begin
				w = 14'd1;
				h = 14'd1;
				k = 14'h3FFF;
			end
			1: begin
				w = 14'd8192;
				h = 14'h3FFF;
				k = 14'd0;
			end
			2: begin
				w = 14'd0;
				h = 14'd2;
				k = 14'd511;
			end
			4: begin
				w = 14'd640;
				h = 14'd480;
				k = 14'h200;
			end
			7: begin
				w = 14'd8191;
				h = 14'd3;
				k = 14'd27;
			end
			default: begin
				w = BND_W'($urandom_range(1, 8192));
				h = BND_W'($urandom_range(1, 8192));
				k = BND_W'($urandom_range(0, 16383));
			end
			endcase
			write_register(CFG_SCREEN_WIDTH, w);
			write_register(CFG_SCREEN_HEIGHT, h);
			write_register(CFG_ESCAPE_KEYCODE, k);
			if (p == 5)
				write_register(CFG_SPARE, 14'h3FFF);
			src_gaps = (p != 2 && p != 6);
			sink_gaps = (p != 3 && p != 6);
			// long sink hold-off with the source flat out: fills the pipe
			if (p == 2)
				hold_req++;
			for (int n = 0; n < PHASE_EVENTS; n++)
				event_queue.push_back(random_event());
		end

		wait_quiet();
		if (fails == 0 && result_queue.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
